### rtl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
`default_nettype none

package bsc_pkg;

    localparam int CAL_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W   = 24;
    localparam int TEMP_W  = 15;
    localparam int PRES_W  = 17;

    // Calibration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SENS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SENS_TC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFF_TC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TREF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TSENS   = 3'd5;

    // Temperature offset and clamp limits at the width of the temperature sum
    localparam logic signed [19:0] TEMP_BASE = 20'sd2000;
    localparam logic signed [19:0] TEMP_LO   = -20'sd4000;
    localparam logic signed [19:0] TEMP_HI   = 20'sd8500;

    // Pressure clamp limits at the width of the final quotient
    localparam logic signed [25:0] PRES_LO = 26'sd1000;
    localparam logic signed [25:0] PRES_HI = 26'sd120000;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temp;
    } t_in_beat;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic [PRES_W-1:0]        pressure_centi_mbar;
    } t_out_beat;

endpackage

`default_nettype wire

### rtl/bsc_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
`default_nettype none

interface bsc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/baro_sensor_compensation.sv
// Pipelined first-order barometric compensation of raw pressure and temperature.
//
// Usage:
//   i_in (sink) takes one beat holding raw_pressure (D1) and raw_temp (D2).
//   o_out (source) gives one beat per input beat: temp_centi, clamped to
//   -40.00..85.00 C, and pressure_centi_mbar, clamped to 10.00..1200.00 mbar.
//   The six calibration words are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data (index 0..5 = C1..C6); other indexes are ignored. Write them
//   only while no beat is in flight.
// Timing:
//   Seven register stages: difference, three 25x17 multiplies, shift/add of
//   TEMP, OFF and SENS, two partial products of D1*SENS, their sum, scale and
//   subtract, final scale and clamp. One beat per cycle is sustained while
//   o_out.ready stays high.
// Reset: all stage valid bits and calibration words clear; no beat is out.
// Stall: each stage takes a beat when it is empty or its beat moves on, so
//   bubbles close up while o_out.ready is low and nothing is lost or repeated.
`default_nettype none

module baro_sensor_compensation (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    bsc_stream_if.sink                      i_in,
    bsc_stream_if.source                    o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bsc_pkg::CAL_W-1:0]  i_cfg_data
);

    localparam int NSTG = 7;

    // Calibration words
    logic [15:0] r_cal_sens, r_cal_off, r_cal_sens_tc, r_cal_off_tc, r_cal_tref, r_cal_tsens;

    // Stage valid bits and ready chain
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_rdy;

    // Stage 0: dT
    logic signed [24:0] r0_dt, n0_dt;
    logic [23:0]        r0_d1;
    // Stage 1: products with dT
    logic signed [41:0] r1_p6, r1_p4, r1_p3, n1_p6, n1_p4, n1_p3;
    logic [23:0]        r1_d1;
    // Stage 2: TEMP, OFF, SENS
    logic signed [14:0] r2_temp, n2_temp;
    logic signed [35:0] r2_off, n2_off;
    logic signed [34:0] r2_sens, n2_sens;
    logic [23:0]        r2_d1;
    // Stage 3: partial products of D1*SENS
    logic [40:0]        r3_pl, n3_pl;
    logic signed [42:0] r3_ph, n3_ph;
    logic signed [14:0] r3_temp;
    logic signed [35:0] r3_off;
    // Stage 4: full product
    logic signed [60:0] r4_prod, n4_prod;
    logic signed [14:0] r4_temp;
    logic signed [35:0] r4_off;
    // Stage 5: scaled product minus OFF
    logic signed [40:0] r5_diff, n5_diff;
    logic signed [14:0] r5_temp;
    // Stage 6: output register
    logic signed [14:0] r6_temp;
    logic [16:0]        r6_pres, n6_pres;

    // Intermediates
    logic signed [41:0] a6, a4, a3;
    logic signed [18:0] q6;
    logic signed [34:0] q4;
    logic signed [33:0] q3;
    logic signed [19:0] temp_sum;
    logic signed [60:0] a_prod;
    logic signed [39:0] q_prod;
    logic signed [40:0] a_diff;
    logic signed [25:0] q_pres;

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_sens    <= '0;
            r_cal_off     <= '0;
            r_cal_sens_tc <= '0;
            r_cal_off_tc  <= '0;
            r_cal_tref    <= '0;
            r_cal_tsens   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsc_pkg::CFG_IDX_SENS:    r_cal_sens    <= i_cfg_data;
                bsc_pkg::CFG_IDX_OFF:     r_cal_off     <= i_cfg_data;
                bsc_pkg::CFG_IDX_SENS_TC: r_cal_sens_tc <= i_cfg_data;
                bsc_pkg::CFG_IDX_OFF_TC:  r_cal_off_tc  <= i_cfg_data;
                bsc_pkg::CFG_IDX_TREF:    r_cal_tref    <= i_cfg_data;
                bsc_pkg::CFG_IDX_TSENS:   r_cal_tsens   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage takes a beat when empty or when its beat advances
    always_comb begin
        stg_rdy[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            stg_rdy[i] = !r_vld[i] || stg_rdy[i+1];
        end
    end

    assign i_in.ready = stg_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (stg_rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Datapath: each quotient truncates toward zero by adding 2^n-1 to
    // negative values before dropping the low n bits.
    always_comb begin
        n0_dt = $signed({1'b0, i_in.data.raw_temp}) - $signed({1'b0, r_cal_tref, 8'd0});

        n1_p6 = r0_dt * $signed({1'b0, r_cal_tsens});
        n1_p4 = r0_dt * $signed({1'b0, r_cal_off_tc});
        n1_p3 = r0_dt * $signed({1'b0, r_cal_sens_tc});

        a6 = r1_p6 + $signed({19'd0, {23{r1_p6[41]}}});
        q6 = a6[41:23];
        a4 = r1_p4 + $signed({35'd0, {7{r1_p4[41]}}});
        q4 = a4[41:7];
        a3 = r1_p3 + $signed({34'd0, {8{r1_p3[41]}}});
        q3 = a3[41:8];

        temp_sum = $signed({q6[18], q6}) + bsc_pkg::TEMP_BASE;
        if (temp_sum < bsc_pkg::TEMP_LO) begin
            n2_temp = bsc_pkg::TEMP_LO[14:0];
        end else if (temp_sum > bsc_pkg::TEMP_HI) begin
            n2_temp = bsc_pkg::TEMP_HI[14:0];
        end else begin
            n2_temp = temp_sum[14:0];
        end
        n2_off  = $signed({4'd0, r_cal_off, 16'd0}) + $signed({q4[34], q4});
        n2_sens = $signed({4'd0, r_cal_sens, 15'd0}) + $signed({q3[33], q3});

        // Split SENS into an unsigned low half and a signed high half
        n3_pl = r2_d1 * r2_sens[16:0];
        n3_ph = $signed({1'b0, r2_d1}) * $signed(r2_sens[34:17]);

        n4_prod = $signed({r3_ph[42], r3_ph, 17'd0}) + $signed({20'd0, r3_pl});

        a_prod  = r4_prod + $signed({40'd0, {21{r4_prod[60]}}});
        q_prod  = a_prod[60:21];
        n5_diff = $signed({q_prod[39], q_prod}) - $signed({{5{r4_off[35]}}, r4_off});

        a_diff = r5_diff + $signed({26'd0, {15{r5_diff[40]}}});
        q_pres = a_diff[40:15];
        if (q_pres < bsc_pkg::PRES_LO) begin
            n6_pres = bsc_pkg::PRES_LO[16:0];
        end else if (q_pres > bsc_pkg::PRES_HI) begin
            n6_pres = bsc_pkg::PRES_HI[16:0];
        end else begin
            n6_pres = q_pres[16:0];
        end
    end

    // Stage registers: payload only, advance with the ready chain
    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r0_dt <= n0_dt;
            r0_d1 <= i_in.data.raw_pressure;
        end
        if (stg_rdy[1]) begin
            r1_p6 <= n1_p6;
            r1_p4 <= n1_p4;
            r1_p3 <= n1_p3;
            r1_d1 <= r0_d1;
        end
        if (stg_rdy[2]) begin
            r2_temp <= n2_temp;
            r2_off  <= n2_off;
            r2_sens <= n2_sens;
            r2_d1   <= r1_d1;
        end
        if (stg_rdy[3]) begin
            r3_pl   <= n3_pl;
            r3_ph   <= n3_ph;
            r3_temp <= r2_temp;
            r3_off  <= r2_off;
        end
        if (stg_rdy[4]) begin
            r4_prod <= n4_prod;
            r4_temp <= r3_temp;
            r4_off  <= r3_off;
        end
        if (stg_rdy[5]) begin
            r5_diff <= n5_diff;
            r5_temp <= r4_temp;
        end
        if (stg_rdy[6]) begin
            r6_temp <= r5_temp;
            r6_pres <= n6_pres;
        end
    end

    assign o_out.valid                    = r_vld[NSTG-1];
    assign o_out.data.temp_centi          = r6_temp;
    assign o_out.data.pressure_centi_mbar = r6_pres;

`ifndef SYNTHESIS
    // Any empty stage lets the input side take a beat
    a_ready_when_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> i_in.ready)
        else $error("input stalled while the pipeline has a free stage");

    // Delivered results lie inside the clamp limits
    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.temp_centi >= -15'sd4000 &&
                         o_out.data.temp_centi <= 15'sd8500 &&
                         o_out.data.pressure_centi_mbar >= 17'd1000 &&
                         o_out.data.pressure_centi_mbar <= 17'd120000))
        else $error("result outside clamp limits");

    // No beat comes out right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
